>>> rtl/sorted_key_table_assert.svh
// assertion macros of the sorted key table checker
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/skt_pkg.sv
// shared types and constants of the sorted key table
`default_nettype none

package skt_pkg;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned GRADE_W     = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DELETE = 2'd2,
		OP_LIST   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_INSERT,
		CM_UPDATE,
		CM_DELETE,
		CM_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic               cmp_en;
		logic [KEY_W-1:0]   new_key;
		logic [GRADE_W-1:0] new_grade;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sorted_key_table.sv
// sorted key table top level: control, result register and the row of cells
// Records live in a row of TABLE_DEPTH cells kept in ascending key order. On the
// cycle a transaction is accepted every cell compares its key with the request key
// and registers the result; in S_APPLY, once the result register is free, the
// insertion point or first match is picked from those flags and the cells move
// their records one place, take the new record or a new grade, all at once. A list
// rotates the row through cell 0, which feeds the result register; after fill_q steps
// the records are back in place, and only the first MAX_RESULTS of them are sent out.
// One transaction is worked on at a time, and a stall on the result side holds the
// work wherever it stands. Slots hold no reset value; only occupied slots are ever read.
`default_nettype none

module sorted_key_table #(
	parameter int unsigned TABLE_DEPTH = skt_pkg::TABLE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    opcode,
	input  wire logic [skt_pkg::KEY_W-1:0]     key,
	input  wire logic [skt_pkg::GRADE_W-1:0]   grade,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [skt_pkg::KEY_W-1:0]          out_key,
	output logic [skt_pkg::GRADE_W-1:0]        out_grade,
	output logic [4:0]                         position,
	output logic [5:0]                         occupancy,
	output logic                               last
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [TABLE_DEPTH-1:0] ONE_V = TABLE_DEPTH'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_LIST
	} state_t;

	state_t                      state_q;
	skt_pkg::opcode_t            op_q;
	logic [skt_pkg::KEY_W-1:0]   req_key_q;
	logic [skt_pkg::GRADE_W-1:0] req_grade_q;
	logic [CW-1:0]               fill_q;
	logic [CW-1:0]               cnt_q;

	logic                        out_valid_q;
	skt_pkg::status_t            status_q;
	logic [skt_pkg::KEY_W-1:0]   out_key_q;
	logic [skt_pkg::GRADE_W-1:0] out_grade_q;
	logic [4:0]                  position_q;
	logic [5:0]                  occupancy_q;
	logic                        last_q;

	logic [skt_pkg::KEY_W-1:0]   cell_key   [TABLE_DEPTH];
	logic [skt_pkg::GRADE_W-1:0] cell_grade [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]      gt_v;
	logic [TABLE_DEPTH-1:0]      eq_v;
	logic [TABLE_DEPTH-1:0]      occ_v;
	logic [TABLE_DEPTH-1:0]      tail_v;
	logic [TABLE_DEPTH-1:0]      ins_pt;
	logic [TABLE_DEPTH-1:0]      first_v;
	logic [TABLE_DEPTH-1:0]      ge_v;
	logic [TABLE_DEPTH-1:0]      mark_v;
	logic [TABLE_DEPTH-1:0]      span_v;
	skt_pkg::cell_ctl_t          ctl;

	logic                        accept;
	logic                        slot_free;
	logic                        found;
	logic                        full;
	logic [7:0]                  pos_w;
	logic [skt_pkg::GRADE_W-1:0] hit_grade;
	skt_pkg::status_t            res_status;
	logic [skt_pkg::KEY_W-1:0]   res_key;
	logic [skt_pkg::GRADE_W-1:0] res_grade;
	logic [4:0]                  res_pos;
	logic [CW-1:0]               res_fill;
	logic                        cnt_emit;
	logic                        cnt_end;
	logic                        cnt_last;
	logic                        res_load;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign full      = (fill_q == CW'(TABLE_DEPTH));
	assign cnt_emit  = (32'(cnt_q) < skt_pkg::MAX_RESULTS);
	assign cnt_end   = (CW'(cnt_q + CW'(1)) == fill_q);
	assign cnt_last  = cnt_end || ((32'(cnt_q) + 32'd1) == skt_pkg::MAX_RESULTS);
	assign res_load  = slot_free && (
		(state_q == S_APPLY && !(op_q == skt_pkg::OP_LIST && fill_q != '0)) ||
		(state_q == S_LIST && cnt_emit));

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			occ_v[i]  = (CW'(i) < fill_q);
			tail_v[i] = (CW'(fill_q - CW'(1)) == CW'(i));
		end
		ins_pt  = ~gt_v & {gt_v[TABLE_DEPTH-2:0], 1'b1};
		first_v = eq_v & (~eq_v + ONE_V);
		ge_v    = ~(first_v - ONE_V);
		found   = |eq_v;

		pos_w     = '0;
		hit_grade = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (op_q == skt_pkg::OP_INSERT) begin
				if (ins_pt[i]) begin
					pos_w = pos_w | 8'(i);
				end
			end else if (first_v[i]) begin
				pos_w     = pos_w | 8'(i);
				hit_grade = hit_grade | cell_grade[i];
			end
		end

		res_status = skt_pkg::ST_OK;
		res_key    = req_key_q;
		res_grade  = '0;
		res_pos    = '0;
		res_fill   = fill_q;
		mark_v     = '0;
		span_v     = '0;
		ctl.mode   = skt_pkg::CM_HOLD;

		case (op_q)
			skt_pkg::OP_INSERT: begin
				res_grade = req_grade_q;
				if (full) begin
					res_status = skt_pkg::ST_FULL;
				end else begin
					res_pos  = pos_w[4:0];
					res_fill = CW'(fill_q + CW'(1));
					mark_v   = ins_pt;
					span_v   = ~gt_v & ~ins_pt;
					ctl.mode = skt_pkg::CM_INSERT;
				end
			end
			skt_pkg::OP_UPDATE, skt_pkg::OP_DELETE: begin
				if (fill_q == '0) begin
					res_status = skt_pkg::ST_EMPTY;
				end else if (!found) begin
					res_status = skt_pkg::ST_NOT_FOUND;
				end else if (op_q == skt_pkg::OP_UPDATE) begin
					res_grade = req_grade_q;
					res_pos   = pos_w[4:0];
					mark_v    = first_v;
					ctl.mode  = skt_pkg::CM_UPDATE;
				end else begin
					res_grade = hit_grade;
					res_pos   = pos_w[4:0];
					res_fill  = CW'(fill_q - CW'(1));
					span_v    = ge_v;
					ctl.mode  = skt_pkg::CM_DELETE;
				end
			end
			default: begin
				res_status = skt_pkg::ST_EMPTY;
				res_key    = '0;
			end
		endcase

		if (state_q == S_LIST) begin
			mark_v   = tail_v;
			span_v   = '0;
			ctl.mode = skt_pkg::CM_ROTATE;
		end
		if (!slot_free || state_q == S_IDLE) begin
			ctl.mode = skt_pkg::CM_HOLD;
		end
		ctl.cmp_en    = accept;
		ctl.new_key   = req_key_q;
		ctl.new_grade = req_grade_q;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		localparam int unsigned LI = (g == 0) ? 0 : g - 1;
		localparam int unsigned RI = (g == TABLE_DEPTH - 1) ? g : g + 1;

		skt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.cmp_key     (key),
			.occ         (occ_v[g]),
			.mark        (mark_v[g]),
			.span        (span_v[g]),
			.left_key    (cell_key[LI]),
			.left_grade  (cell_grade[LI]),
			.right_key   (cell_key[RI]),
			.right_grade (cell_grade[RI]),
			.wrap_key    (cell_key[0]),
			.wrap_grade  (cell_grade[0]),
			.cell_key    (cell_key[g]),
			.cell_grade  (cell_grade[g]),
			.gt          (gt_v[g]),
			.eq          (eq_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= skt_pkg::opcode_t'(opcode);
						req_key_q   <= key;
						req_grade_q <= grade;
						state_q     <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (slot_free) begin
						if (op_q == skt_pkg::OP_LIST && fill_q != '0) begin
							cnt_q   <= '0;
							state_q <= S_LIST;
						end else begin
							status_q    <= res_status;
							out_key_q   <= res_key;
							out_grade_q <= res_grade;
							position_q  <= res_pos;
							occupancy_q <= 6'(res_fill);
							last_q      <= 1'b1;
							fill_q      <= res_fill;
							state_q     <= S_IDLE;
						end
					end
				end
				S_LIST: begin
					if (slot_free) begin
						if (cnt_emit) begin
							status_q    <= skt_pkg::ST_OK;
							out_key_q   <= cell_key[0];
							out_grade_q <= cell_grade[0];
							position_q  <= 5'(cnt_q);
							occupancy_q <= 6'(fill_q);
							last_q      <= cnt_last;
						end
						cnt_q <= CW'(cnt_q + CW'(1));
						if (cnt_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_grade = out_grade_q;
	assign position  = position_q;
	assign occupancy = occupancy_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> rtl/skt_cell.sv
// one table cell: a record, its key compare flags and neighbor moves
`default_nettype none

module skt_cell (
	input  wire logic                           clk,
	input  wire skt_pkg::cell_ctl_t             ctl,
	input  wire logic [skt_pkg::KEY_W-1:0]      cmp_key,
	input  wire logic                           occ,
	input  wire logic                           mark,
	input  wire logic                           span,
	input  wire logic [skt_pkg::KEY_W-1:0]      left_key,
	input  wire logic [skt_pkg::GRADE_W-1:0]    left_grade,
	input  wire logic [skt_pkg::KEY_W-1:0]      right_key,
	input  wire logic [skt_pkg::GRADE_W-1:0]    right_grade,
	input  wire logic [skt_pkg::KEY_W-1:0]      wrap_key,
	input  wire logic [skt_pkg::GRADE_W-1:0]    wrap_grade,
	output logic      [skt_pkg::KEY_W-1:0]      cell_key,
	output logic      [skt_pkg::GRADE_W-1:0]    cell_grade,
	output logic                                gt,
	output logic                                eq
);

	logic [skt_pkg::KEY_W-1:0]   key_q;
	logic [skt_pkg::GRADE_W-1:0] grade_q;
	logic                        gt_q;
	logic                        eq_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			gt_q <= occ && (cmp_key > key_q);
			eq_q <= occ && (cmp_key == key_q);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mode)
			skt_pkg::CM_INSERT: begin
				if (mark) begin
					key_q   <= ctl.new_key;
					grade_q <= ctl.new_grade;
				end else if (span) begin
					key_q   <= left_key;
					grade_q <= left_grade;
				end
			end
			skt_pkg::CM_UPDATE: begin
				if (mark) begin
					grade_q <= ctl.new_grade;
				end
			end
			skt_pkg::CM_DELETE: begin
				if (span) begin
					key_q   <= right_key;
					grade_q <= right_grade;
				end
			end
			skt_pkg::CM_ROTATE: begin
				if (mark) begin
					key_q   <= wrap_key;
					grade_q <= wrap_grade;
				end else begin
					key_q   <= right_key;
					grade_q <= right_grade;
				end
			end
			default: begin
			end
		endcase
	end

	assign cell_key   = key_q;
	assign cell_grade = grade_q;
	assign gt         = gt_q;
	assign eq         = eq_q;

endmodule

`default_nettype wire

>>> rtl/skt_checker.sv
// port-level checker of the sorted key table and its bind
`default_nettype none

`include "sorted_key_table_assert.svh"

module skt_checker #(
	parameter int unsigned TABLE_DEPTH = skt_pkg::TABLE_DEPTH
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [1:0]                    status,
	input wire logic [skt_pkg::KEY_W-1:0]     out_key,
	input wire logic [5:0]                    occupancy,
	input wire logic                          last
);

	// stalled result transaction holds
	`SKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_key) && $stable(status) && $stable(last), "result changed while stalled")

	// one transaction at a time
	`SKT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input taken while busy")

	// a failing status closes the transaction
	`SKT_ASSERT_NOW(a_fail_is_last, out_valid && (status != skt_pkg::ST_OK), last, "failing result not last")

	// full only when every slot is taken
	`SKT_ASSERT_NOW(a_full_count, out_valid && (status == skt_pkg::ST_FULL), occupancy == 6'(TABLE_DEPTH), "full status with free slots")

	// empty only when no record is stored
	`SKT_ASSERT_NOW(a_empty_count, out_valid && (status == skt_pkg::ST_EMPTY), occupancy == 6'd0, "empty status with records stored")

endmodule

bind sorted_key_table skt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_skt_checker (.*);

`default_nettype wire

>>> tb/sorted_key_table_monitor.sv
// result checker for the sorted key table: tracks the records, predicts every result and compares
module sorted_key_table_monitor
	import skt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [KEY_W-1:0]     key,
	input  logic [GRADE_W-1:0]   grade,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic [KEY_W-1:0]     out_key,
	input  logic [GRADE_W-1:0]   out_grade,
	input  logic [4:0]           position,
	input  logic [5:0]           occupancy,
	input  logic                 last,
	output int                   fail_count,
	output int                   pending
);
	typedef struct {
		logic [KEY_W-1:0]   rec_key;
		logic [GRADE_W-1:0] rec_grade;
	} record_t;

	typedef struct {
		status_t            st;
		logic [KEY_W-1:0]   k;
		logic [GRADE_W-1:0] g;
		logic [4:0]         pos;
		logic [5:0]         occ;
		logic               fin;
	} result_t;

	record_t records_q[$];
	result_t expected_q[$];
	result_t want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic result_t make_result(status_t st, logic [KEY_W-1:0] k,
		logic [GRADE_W-1:0] g, int pos, logic fin);
		result_t r;
		r.st = st;
		r.k = k;
		r.g = g;
		r.pos = pos[4:0];
		r.occ = 6'(records_q.size());
		r.fin = fin;
		return r;
	endfunction

	task automatic apply_operation(opcode_t op, logic [KEY_W-1:0] k, logic [GRADE_W-1:0] g);
		int idx;
		int n;
		record_t rec;
		case (op)
		OP_INSERT: begin
			if (records_q.size() >= TABLE_DEPTH) begin
				expected_q.push_back(make_result(ST_FULL, k, g, 0, 1'b1));
			end else begin
				idx = 0;
				while (idx < records_q.size() && k > records_q[idx].rec_key)
					idx++;
				rec.rec_key = k;
				rec.rec_grade = g;
				records_q.insert(idx, rec);
				expected_q.push_back(make_result(ST_OK, k, g, idx, 1'b1));
			end
		end
		OP_UPDATE, OP_DELETE: begin
			if (records_q.size() == 0) begin
				expected_q.push_back(make_result(ST_EMPTY, k, '0, 0, 1'b1));
			end else begin
				idx = -1;
				for (int i = records_q.size() - 1; i >= 0; i--)
					if (records_q[i].rec_key == k)
						idx = i;
				if (idx < 0) begin
					expected_q.push_back(make_result(ST_NOT_FOUND, k, '0, 0, 1'b1));
				end else if (op == OP_UPDATE) begin
					records_q[idx].rec_grade = g;
					expected_q.push_back(make_result(ST_OK, k, g, idx, 1'b1));
				end else begin
					rec = records_q[idx];
					records_q.delete(idx);
					expected_q.push_back(make_result(ST_OK, k, rec.rec_grade, idx, 1'b1));
				end
			end
		end
		default: begin
			if (records_q.size() == 0) begin
				expected_q.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
			end else begin
				n = (records_q.size() < MAX_RESULTS) ? records_q.size() : MAX_RESULTS;
				for (int i = 0; i < n; i++)
					expected_q.push_back(make_result(ST_OK, records_q[i].rec_key,
						records_q[i].rec_grade, i, i == n - 1));
			end
		end
		endcase
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
		$display("mismatch at %0t: %s got %h expected %h", $time, field, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			records_q.delete();
			expected_q.delete();
		end else begin
			if (in_valid && !in_stall)
				apply_operation(opcode_t'(opcode), key, grade);
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("transaction with nothing expected, key", out_key, '0);
				end else begin
					want = expected_q.pop_front();
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (out_key !== want.k)
						report_mismatch("out_key", out_key, want.k);
					if (out_grade !== want.g)
						report_mismatch("out_grade", out_grade, want.g);
					if (position !== want.pos)
						report_mismatch("position", position, want.pos);
					if (occupancy !== want.occ)
						report_mismatch("occupancy", occupancy, want.occ);
					if (last !== want.fin)
						report_mismatch("last", last, want.fin);
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

>>> tb/testbench.sv
// top of the sorted key table testbench: clock, reset, stimulus, stalls and verdict
module testbench;
	import skt_pkg::*;

	localparam int RANDOM_ITEMS   = 300;
	localparam int FILL_ITEMS     = 60;
	localparam int HOLD_CYCLES    = 200;
	localparam int HOLD_AFTER     = 40;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	opcode_t              opcode;
	logic [KEY_W-1:0]     key;
	logic [GRADE_W-1:0]   grade;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic [KEY_W-1:0]     out_key;
	logic [GRADE_W-1:0]   out_grade;
	logic [4:0]           position;
	logic [5:0]           occupancy;
	logic                 last;
	int                   fail_count;
	int                   pending;
	int                   inputs_taken;
	logic [KEY_W-1:0]     key_pool[$];

	sorted_key_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.key       (key),
		.grade     (grade),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_key   (out_key),
		.out_grade (out_grade),
		.position  (position),
		.occupancy (occupancy),
		.last      (last)
	);

	sorted_key_table_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.key        (key),
		.grade      (grade),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_key    (out_key),
		.out_grade  (out_grade),
		.position   (position),
		.occupancy  (occupancy),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(opcode_t op, logic [KEY_W-1:0] k, logic [GRADE_W-1:0] g);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		grade <= g;
		do @(posedge clk); while (in_stall);
		inputs_taken++;
		@(negedge clk);
		if (op == OP_INSERT && k > 23) begin
			key_pool.push_back(k);
			if (key_pool.size() > 16)
				void'(key_pool.pop_front());
		end
	endtask

	task automatic send_random(int ins_w, int upd_w, int del_w);
		int r;
		opcode_t op;
		logic [KEY_W-1:0] k;
		logic [GRADE_W-1:0] g;
		r = $urandom_range(0, 99);
		if (r < ins_w)
			op = OP_INSERT;
		else if (r < ins_w + upd_w)
			op = OP_UPDATE;
		else if (r < ins_w + upd_w + del_w)
			op = OP_DELETE;
		else
			op = OP_LIST;
		r = $urandom_range(0, 9);
		if (r < 5)
			k = $urandom_range(0, 23);
		else if (r < 7 && key_pool.size() > 0)
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (r < 9)
			k = $urandom;
		else
			k = ($urandom_range(0, 1) != 0) ? '1 : '0;
		g = ($urandom_range(0, 15) == 0) ? '1 : 16'($urandom);
		send_item(op, k, g);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// result side stalls, with one long hold-off while the table fills
	initial begin
		int n;
		bit hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && inputs_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				n = HOLD_CYCLES;
			end else if ($urandom_range(0, 1) != 0) begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 20);
			end else begin
				out_stall <= 1'b1;
				n = random_gap() + 1;
			end
			repeat (n) @(negedge clk);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int done_items;
		int phase_len;
		int kind;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		key = '0;
		grade = '0;
		inputs_taken = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table cases
		send_item(OP_LIST, 32'd9, 16'd9);
		send_item(OP_UPDATE, 32'd7, 16'd1);
		send_item(OP_DELETE, 32'd7, 16'd1);
		// extremes and duplicates
		send_item(OP_INSERT, '0, '0);
		send_item(OP_INSERT, '1, '1);
		send_item(OP_INSERT, 32'd5, 16'd100);
		send_item(OP_INSERT, 32'd5, 16'd200);
		send_item(OP_INSERT, 32'd3, 16'd55);
		send_item(OP_INSERT, 32'hAAAA_AAAA, 16'h5555);
		send_item(OP_INSERT, 32'h5555_5555, 16'hAAAA);
		send_item(OP_LIST, '0, '0);
		send_item(OP_UPDATE, 32'd5, 16'd999);
		send_item(OP_UPDATE, 32'd6, 16'd1);
		send_item(OP_DELETE, 32'd5, 16'd0);
		send_item(OP_DELETE, 32'd6, 16'd0);
		send_item(OP_LIST, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '1, '0);
		send_item(OP_DELETE, 32'd5, '0);
		send_item(OP_DELETE, 32'd3, '0);
		send_item(OP_DELETE, 32'hAAAA_AAAA, '0);
		send_item(OP_DELETE, 32'h5555_5555, '0);
		send_item(OP_LIST, '1, '1);
		pause_until_drained();

		// grow past full first, then mixed phases
		repeat (FILL_ITEMS) send_random(85, 5, 5);
		send_item(OP_LIST, '0, '0);
		pause_until_drained();
		done_items = FILL_ITEMS;
		while (done_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 50);
			repeat (phase_len) begin
				case (kind)
				0: send_random(80, 8, 6);
				1: send_random(15, 10, 65);
				default: send_random(35, 20, 30);
				endcase
			end
			done_items += phase_len;
			if ($urandom_range(0, 1) != 0)
				pause_until_drained();
		end
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
